>>> rtl/dcf_pkg.sv
package dcf_pkg;

	localparam int unsigned SCORE_W      = 16;
	localparam int unsigned COORD_W      = 16;
	localparam int unsigned SCALE_W      = 16;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CLASS_IDX_W  = 2;
	localparam int unsigned SIZE_W       = 15;

	// Number of classes of the detector head and the number of score inputs of a row.
	localparam int unsigned NUM_CLASSES  = 4;
	localparam int unsigned SCORE_INPUTS = 4;
	// Classes that actually take part in the best-class search.
	localparam int unsigned NCLS_EFF     = (NUM_CLASSES > SCORE_INPUTS) ? SCORE_INPUTS :
		((NUM_CLASSES < 1) ? 1 : NUM_CLASSES);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_OBJ_THR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLASS_THR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE   = 2'd3;

	localparam logic [CFG_DATA_W-1:0] OBJ_THR_RST   = 16'd51773;
	localparam logic [CFG_DATA_W-1:0] CLASS_THR_RST = 16'd45875;
	localparam logic [CFG_DATA_W-1:0] SCALE_RST     = 16'd4096;

	typedef struct packed {
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] box_w;
		logic [COORD_W-1:0] box_h;
		logic [SCORE_W-1:0] objectness;
		logic [SCORE_W-1:0] class_score_0;
		logic [SCORE_W-1:0] class_score_1;
		logic [SCORE_W-1:0] class_score_2;
		logic [SCORE_W-1:0] class_score_3;
	} row_t;

	typedef struct packed {
		logic [CLASS_IDX_W-1:0] class_index;
		logic [SCORE_W-1:0]     kept_confidence;
		logic signed [15:0]     box_left;
		logic signed [15:0]     box_top;
		logic [SIZE_W-1:0]      box_width;
		logic [SIZE_W-1:0]      box_height;
	} box_t;

endpackage

>>> rtl/dcf_stream_if.sv
interface dcf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/detection_candidate_filter.sv
// A row taken on rows passes through the stage 1, stage 2 and stage 3 registers in turn,
// and its result is offered on boxes from the stage 3 register. Throughput: one row per cycle
// while boxes does not stall; the three stages (compare, multiply, round) each hold one row.
// A row that fails either threshold is dropped at the second stage and gives no transfer.
// Reset (arst_n low, asynchronous): all stage valid bits clear and the four configuration
// registers return to objectness 51773, class 45875 and both scales 4096 (1.0).
module detection_candidate_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	dcf_stream_if.sink                          rows,
	dcf_stream_if.source                        boxes,
	input  logic                                cfg_we,
	input  logic [dcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dcf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dcf_pkg::*;

	// Configuration registers.
	logic [SCORE_W-1:0] obj_thr_q;
	logic [SCORE_W-1:0] class_thr_q;
	logic [SCALE_W-1:0] x_scale_q;
	logic [SCALE_W-1:0] y_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_thr_q   <= OBJ_THR_RST;
			class_thr_q <= CLASS_THR_RST;
			x_scale_q   <= SCALE_RST;
			y_scale_q   <= SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBJ_THR:   obj_thr_q   <= cfg_data;
				REG_CLASS_THR: class_thr_q <= cfg_data;
				REG_X_SCALE:   x_scale_q   <= cfg_data;
				REG_Y_SCALE:   y_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage accepts a new row when it is empty or when the stage after it moves on,
	// so bubbles close up and a waiting result does not block the stages behind it.
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3     = !v_s3 || boxes.ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign rows.ready = rdy_s1;

	// ---------------------------------------------------------------- stage 1
	// Objectness compare, first round of the best-class search on pairs, and the doubled
	// centre minus size for both axes (left = (2*cx - w) * scale / 2^19).
	logic [SCORE_INPUTS-1:0][SCORE_W-1:0] score_m;
	logic [SCORE_W-1:0] best01, best23;
	logic               pick1, pick3;

	always_comb begin
		score_m[0] = rows.data.class_score_0;
		score_m[1] = rows.data.class_score_1;
		score_m[2] = rows.data.class_score_2;
		score_m[3] = rows.data.class_score_3;
		// A class beyond the head's class count scores zero; it then never beats a lower
		// index, because a tie keeps the lower index.
		for (int i = 0; i < SCORE_INPUTS; i++) begin
			if (i >= NCLS_EFF) begin
				score_m[i] = '0;
			end
		end
		pick1  = score_m[1] > score_m[0];
		pick3  = score_m[3] > score_m[2];
		best01 = pick1 ? score_m[1] : score_m[0];
		best23 = pick3 ? score_m[3] : score_m[2];
	end

	logic [SCORE_W-1:0]       best01_s1, best23_s1, conf_s1;
	logic                     pick1_s1, pick3_s1, obj_ok_s1;
	logic signed [COORD_W+1:0] dx_s1, dy_s1;
	logic [COORD_W-1:0]       bw_s1, bh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= rows.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && rows.valid) begin
			best01_s1 <= best01;
			best23_s1 <= best23;
			pick1_s1  <= pick1;
			pick3_s1  <= pick3;
			conf_s1   <= rows.data.objectness;
			obj_ok_s1 <= rows.data.objectness >= obj_thr_q;
			dx_s1     <= signed'({1'b0, rows.data.center_x, 1'b0}) -
				signed'({2'b00, rows.data.box_w});
			dy_s1     <= signed'({1'b0, rows.data.center_y, 1'b0}) -
				signed'({2'b00, rows.data.box_h});
			bw_s1     <= rows.data.box_w;
			bh_s1     <= rows.data.box_h;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Final round of the class search and the class threshold, in parallel with the four
	// scale products. A rejected row is dropped here.
	localparam int unsigned EPROD_W = COORD_W + 2 + SCALE_W + 1;
	localparam int unsigned SPROD_W = COORD_W + SCALE_W;

	logic                   pick_hi;
	logic [SCORE_W-1:0]     best;
	logic [CLASS_IDX_W-1:0] best_idx;
	logic                   keep;

	always_comb begin
		pick_hi  = best23_s1 > best01_s1;
		best     = pick_hi ? best23_s1 : best01_s1;
		best_idx = pick_hi ? {1'b1, pick3_s1} : {1'b0, pick1_s1};
		keep     = obj_ok_s1 && (best > class_thr_q);
	end

	logic signed [EPROD_W-1:0] px_s2, py_s2;
	logic [SPROD_W-1:0]        pw_s2, ph_s2;
	logic [CLASS_IDX_W-1:0]    cls_s2;
	logic [SCORE_W-1:0]        conf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			px_s2   <= EPROD_W'(dx_s1) * EPROD_W'(signed'({1'b0, x_scale_q}));
			py_s2   <= EPROD_W'(dy_s1) * EPROD_W'(signed'({1'b0, y_scale_q}));
			pw_s2   <= SPROD_W'(bw_s1) * SPROD_W'(x_scale_q);
			ph_s2   <= SPROD_W'(bh_s1) * SPROD_W'(y_scale_q);
			cls_s2  <= best_idx;
			conf_s2 <= conf_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Edges: an arithmetic shift rounds down, so a negative product with a nonzero
	// fraction gets one added back to round toward zero. With 16-bit inputs the edges stay
	// within -8191 to 16383 and the sizes within 14 bits, so no clipping is ever needed.
	logic signed [15:0] left_c, top_c;
	logic [SIZE_W-1:0]  width_c, height_c;

	always_comb begin
		left_c   = signed'(px_s2[EPROD_W-1:19]) +
			signed'({15'd0, px_s2[EPROD_W-1] && (|px_s2[18:0])});
		top_c    = signed'(py_s2[EPROD_W-1:19]) +
			signed'({15'd0, py_s2[EPROD_W-1] && (|py_s2[18:0])});
		width_c  = {1'b0, pw_s2[SPROD_W-1:18]};
		height_c = {1'b0, ph_s2[SPROD_W-1:18]};
	end

	box_t box_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			box_s3.class_index     <= cls_s2;
			box_s3.kept_confidence <= conf_s2;
			box_s3.box_left        <= left_c;
			box_s3.box_top         <= top_c;
			box_s3.box_width       <= width_c;
			box_s3.box_height      <= height_c;
		end
	end

	assign boxes.valid = v_s3;
	assign boxes.data  = box_s3;

	// ---------------------------------------------------------------- checks
	// The input side only stalls when every stage is occupied and the output is stalled.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rows.ready |-> (v_s1 && v_s2 && v_s3 && !boxes.ready))
		else $error("input stalled while the pipeline has room");

	// A result held at the output keeps its contents while it waits.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !boxes.ready) |=> (v_s3 && $stable(box_s3)))
		else $error("waiting result was overwritten");

	// Edges stay inside the range that the 16-bit inputs allow.
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		boxes.valid |-> (box_s3.box_left >= -16'sd8192) && (box_s3.box_left <= 16'sd16383) &&
			(box_s3.box_top >= -16'sd8192) && (box_s3.box_top <= 16'sd16383))
		else $error("box edge out of range");

endmodule
